/* rtl/core/rbd_pkg.sv */
// Package for the reversible bounded deque: request codes.
`default_nettype none

package rbd_pkg;

  // Request codes carried on the operation field
  typedef enum logic [1:0] {
    OP_INSERT_HEAD = 2'd0,
    OP_INSERT_TAIL = 2'd1,
    OP_REMOVE_HEAD = 2'd2,
    OP_REVERSE     = 2'd3
  } op_t;

endpackage : rbd_pkg

`default_nettype wire

/* rtl/core/reversible_bounded_deque_top.sv */
// Reversible bounded deque: ring store in one synchronous memory plus pointer state.
`default_nettype none

// Usage
//   Input channel: drive in_operation and in_value_in with start high; the beat
//   is taken at a rising edge where start is high and busy is low.
//   Requests: insert at head, insert at tail, remove head, reverse order.
//   Result channel: out_valid is high for exactly one cycle, the cycle after
//   the request is taken, carrying out_ok, out_removed_value and out_count.
//   The receiver cannot stall; each result must be captured in its cycle.
// Throughput
//   One request per cycle sustained while busy is low: the
//   pointer, count and direction registers update at the accepting edge and
//   the memory's single write port and single registered read port each see
//   at most one access per request (inserts write, every request reads the head).
// Reset
//   rst_n (synchronous, active low) empties the deque, restores normal order
//   and holds busy high during reset; busy is registered and clears once rst_n is released.
//   Memory contents are not cleared; only written entries ever reach out_removed_value.
module reversible_bounded_deque_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  rbd_pkg::op_t                       in_operation,
  input  wire  signed [DATA_WIDTH-1:0]       in_value_in,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic signed [DATA_WIDTH-1:0]       out_removed_value,
  output logic [$clog2(DEPTH+1)-1:0]         out_count
);

  import rbd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] ONE_A   = AW'(1);

  // Ring arithmetic: base plus or minus an offset below DEPTH, modulo DEPTH
  function automatic logic [AW-1:0] ring_fwd(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] s;
    if (base >= off) s = {1'b0, base} - {1'b0, off};
    else             s = {1'b0, base} + DEPTH_W - {1'b0, off};
    return s[AW-1:0];
  endfunction

  // Slot lying off steps from the head in head-to-tail order
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] front,
                                            input logic           rev,
                                            input logic [AW-1:0] off);
    return rev ? ring_back(front, off) : ring_fwd(front, off);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          busy_r;
  logic          out_valid_r, ok_nxt, out_ok_r, take_r, take_nxt;
  logic [CW-1:0] out_count_r;

  logic          accept;
  logic          we;
  logic [AW-1:0] waddr;
  logic          is_full, is_empty;

  assign accept   = start && !busy_r;
  assign is_full  = (count_r == DEPTH_C);
  assign is_empty = (count_r == '0);

  // Decode the request against the current pointer state
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    ok_nxt    = 1'b0;
    take_nxt  = 1'b0;
    we        = 1'b0;
    waddr     = front_r;
    unique case (in_operation)
      OP_INSERT_HEAD: begin
        if (!is_full) begin
          front_nxt = rev_r ? ring_fwd(front_r, ONE_A) : ring_back(front_r, ONE_A);
          waddr     = front_nxt;
          we        = accept;
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      OP_INSERT_TAIL: begin
        if (!is_full) begin
          waddr     = slot_at(front_r, rev_r, count_r[AW-1:0]);
          we        = accept;
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      OP_REMOVE_HEAD: begin
        if (!is_empty) begin
          front_nxt = slot_at(front_r, rev_r, ONE_A);
          count_nxt = count_r - CW'(1);
          take_nxt  = 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_REVERSE: begin
        if (!is_empty) begin
          front_nxt = slot_at(front_r, rev_r, AW'(count_r - CW'(1)));
        end
        rev_nxt = !rev_r;
        ok_nxt  = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Write inserted beats, read the head slot on every accepted beat
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_value_in;
    end
    if (accept) begin
      rd_data_r <= mem[front_r];
    end
  end

  // Advance pointer state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      take_r      <= 1'b0;
      out_count_r <= '0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        front_r     <= front_nxt;
        count_r     <= count_nxt;
        rev_r       <= rev_nxt;
        out_ok_r    <= ok_nxt;
        take_r      <= take_nxt;
        out_count_r <= count_nxt;
      end
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_count         = out_count_r;
  assign out_removed_value = take_r ? rd_data_r : '0;

`ifndef SYNTHESIS
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result beat missing after accepted request");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result beat without an accepted request");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("element count exceeds depth");

  a_empty_remove_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_REMOVE_HEAD && is_empty)
      |=> (!out_ok && out_removed_value == '0 && out_count == '0))
    else $error("remove from empty deque reported success");

  a_full_insert_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_full &&
     (in_operation == OP_INSERT_HEAD || in_operation == OP_INSERT_TAIL))
      |=> (!out_ok && out_count == DEPTH_C))
    else $error("insert into full deque reported success");
`endif

endmodule : reversible_bounded_deque_top

`default_nettype wire
